// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BSIT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When ante holds, cons must hold on the same edge.
`define BSIT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// When ante holds, cons must hold on the next edge.
`define BSIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bsit_pkg.sv =====
// Types and constants for the bounded sorted insert table.
package bsit_pkg;

	localparam int DEPTH        = 32;
	localparam int PAYLOAD_BITS = 16;
	localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W        = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] sort_key;
		logic [15:0] payload_tag;
		logic [4:0]  read_index;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        evicted;
		logic [4:0]  placed_at;
		logic [5:0]  entry_count;
		logic        entry_valid;
		logic [31:0] entry_key;
		logic [15:0] entry_payload;
	} rsp_t;

	// Broadcast to every cell for the item being taken.
	typedef struct packed {
		logic                    insert;
		logic                    clear;
		logic [31:0]             key;
		logic [PAYLOAD_BITS-1:0] payload;
	} cell_ctl_t;

	// What a cell shows to its right-hand neighbor and to the read mux.
	typedef struct packed {
		logic                    valid;
		logic                    ge;
		logic [31:0]             key;
		logic [PAYLOAD_BITS-1:0] payload;
	} cell_t;

endpackage

// ===== rtl/core/bsit_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts or captures on insert.
module bsit_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  bsit_pkg::cell_ctl_t ctl,
	input  bsit_pkg::cell_t    prev,
	output bsit_pkg::cell_t    cur,
	output logic               take_new
);

	logic                              valid_q;
	logic [31:0]                       key_q;
	logic [bsit_pkg::PAYLOAD_BITS-1:0] payload_q;
	logic                              ge;

	// Entries with key >= new key form a prefix; the new item lands at its end.
	assign ge       = valid_q && (key_q >= ctl.key);
	assign take_new = !ge && prev.ge;

	assign cur.valid   = valid_q;
	assign cur.ge      = ge;
	assign cur.key     = key_q;
	assign cur.payload = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && !ge) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && !ge) begin
			if (prev.ge) begin
				key_q     <= ctl.key;
				payload_q <= ctl.payload;
			end else begin
				key_q     <= prev.key;
				payload_q <= prev.payload;
			end
		end
	end

endmodule

// ===== rtl/core/bounded_sorted_insert_table.sv =====
// Top level of the bounded sorted insert table: cell chain, read mux, result register.
//
// Keeps up to DEPTH (key, tag) entries in descending key order, equal keys in
// arrival order. Request channel (req, req_valid, req_stall) carries one
// operation per item: insert, clear, read or no-op. Response channel
// (rsp, rsp_valid, rsp_stall) returns exactly one result item per request.
// Each slot is a cell that compares its key with the incoming one and either
// keeps its entry, captures the new one or takes its left neighbor's, so an
// insert and its shift are done together, with no separate shift pass.
// A taken request's result is registered and shows in the cycle after it is taken.
// Throughput: one item per cycle while the response side does not stall;
// the single result register is the only buffering.
// When rsp_stall is high with a result waiting, req_stall rises in the same
// cycle and the held result stays unchanged until taken.
// Reset empties the table (count zero, all cells invalid) and drops any
// pending result; no clearing pass is needed.
module bounded_sorted_insert_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bsit_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bsit_pkg::rsp_t rsp
);

	localparam int DEPTH = bsit_pkg::DEPTH;
	localparam int IDX_W = bsit_pkg::IDX_W;
	localparam int CNT_W = bsit_pkg::CNT_W;

	bsit_pkg::cell_ctl_t ctl;
	bsit_pkg::cell_t     head;
	bsit_pkg::cell_t     cells [DEPTH];
	logic [DEPTH-1:0]    take_new;

	logic             take;
	logic             is_insert;
	logic             is_clear;
	logic             is_read;
	logic             full;
	logic             ins_ok;
	logic [IDX_W-1:0] place_idx;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_hit;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	bsit_pkg::rsp_t   rsp_nxt;
	bsit_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_insert = take && (req.operation == bsit_pkg::OP_INSERT);
	assign is_clear  = take && (req.operation == bsit_pkg::OP_CLEAR);
	assign is_read   = (req.operation == bsit_pkg::OP_READ);

	assign ctl.insert  = is_insert;
	assign ctl.clear   = is_clear;
	assign ctl.key     = req.sort_key;
	assign ctl.payload = bsit_pkg::PAYLOAD_BITS'(req.payload_tag);

	// Virtual cell left of slot 0: always valid and always ahead of the new key.
	assign head.valid   = 1'b1;
	assign head.ge      = 1'b1;
	assign head.key     = '0;
	assign head.payload = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bsit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev     ((i == 0) ? head : cells[(i == 0) ? 0 : i - 1]),
			.cur      (cells[i]),
			.take_new (take_new[i])
		);
	end

	// Rejected when every slot is valid and ahead of the new key.
	assign full   = (32'(count_q) == DEPTH);
	assign ins_ok = !cells[DEPTH-1].ge;

	always_comb begin
		place_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (take_new[i]) begin
				place_idx = place_idx | IDX_W'(i);
			end
		end
	end

	assign rd_idx = IDX_W'(req.read_index);
	assign rd_hit = (32'(req.read_index) < 32'(count_q)) && (32'(req.read_index) < DEPTH);

	always_comb begin
		count_nxt = count_q;
		unique case (req.operation)
			bsit_pkg::OP_INSERT: begin
				if (ins_ok && !full) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			bsit_pkg::OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase

		rsp_nxt               = '0;
		rsp_nxt.entry_count   = 6'(count_nxt);
		if (req.operation == bsit_pkg::OP_INSERT && ins_ok) begin
			rsp_nxt.accepted  = 1'b1;
			rsp_nxt.evicted   = full;
			rsp_nxt.placed_at = 5'(place_idx);
		end
		if (is_read && rd_hit) begin
			rsp_nxt.entry_valid   = 1'b1;
			rsp_nxt.entry_key     = cells[rd_idx].key;
			rsp_nxt.entry_payload = 16'(cells[rd_idx].payload);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

// ===== rtl/core/bsit_checker.sv =====
// Port-level checks for the bounded sorted insert table, bound to the top level.
`include "assert_macros.svh"

module bsit_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input bsit_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input bsit_pkg::rsp_t rsp
);

	`BSIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

	`BSIT_ASSERT_NEXT(a_one_cycle, req_valid && !req_stall, rsp_valid, "no result one cycle after a taken item")

	`BSIT_ASSERT_SAME(a_evict_full, rsp_valid && rsp.evicted, rsp.accepted && (32'(rsp.entry_count) == bsit_pkg::DEPTH), "eviction without a full table")

	`BSIT_ASSERT_SAME(a_reject_quiet, rsp_valid && !rsp.accepted, !rsp.evicted && (rsp.placed_at == 5'd0), "rejected insert reports a placement")

	`BSIT_ASSERT_ALWAYS(a_count_bound, !rsp_valid || (32'(rsp.entry_count) <= bsit_pkg::DEPTH), "entry count above depth")

endmodule

bind bounded_sorted_insert_table bsit_checker u_bsit_checker (.*);

// ===== verif/top_k_checker.sv =====
// Checker for the sorted insert table: mirrors the table, predicts each result item, compares.
`timescale 1ns / 1ps
module top_k_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  bsit_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  bsit_pkg::rsp_t  rsp,
	output int              mismatches,
	output int              outstanding,
	output int              n_items,
	output int              n_placed,
	output int              n_evicted,
	output int              n_rejected,
	output int              n_read_hits
);
	import bsit_pkg::*;

	logic [31:0]             mirror_keys [DEPTH];
	logic [PAYLOAD_BITS-1:0] mirror_tags [DEPTH];
	int                      mirror_count;
	rsp_t                    due_results [$];
	rsp_t                    want;
	rsp_t                    predicted;

	// Applies one request to the mirrored table and returns the result it should produce.
	function automatic rsp_t apply_to_mirror(req_t r);
		rsp_t res;
		int   pos;
		int   i;
		res = '0;
		case (op_t'(r.operation))
			OP_INSERT: begin
				pos = mirror_count;
				// lands after every entry whose key is not below the new one
				while (pos > 0 && mirror_keys[pos-1] < r.sort_key)
					pos--;
				if (pos < DEPTH) begin
					if (mirror_count == DEPTH) begin
						res.evicted = 1'b1;
						mirror_count--;
					end
					for (i = mirror_count; i > pos; i--) begin
						mirror_keys[i] = mirror_keys[i-1];
						mirror_tags[i] = mirror_tags[i-1];
					end
					mirror_keys[pos] = r.sort_key;
					mirror_tags[pos] = r.payload_tag[PAYLOAD_BITS-1:0];
					mirror_count++;
					res.accepted  = 1'b1;
					res.placed_at = 5'(pos);
				end
			end
			OP_CLEAR: begin
				mirror_count = 0;
			end
			OP_READ: begin
				if (int'(r.read_index) < mirror_count) begin
					res.entry_valid   = 1'b1;
					res.entry_key     = mirror_keys[r.read_index];
					res.entry_payload = 16'(mirror_tags[r.read_index]);
				end
			end
			default: ;
		endcase
		res.entry_count = 6'(mirror_count);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_count = 0;
			due_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
			n_items     <= 0;
			n_placed    <= 0;
			n_evicted   <= 0;
			n_rejected  <= 0;
			n_read_hits <= 0;
		end else begin
			// results first: a result leaving now belongs to an earlier item
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] result item with nothing due: %p", $time, rsp);
					mismatches <= mismatches + 1;
				end else begin
					want = due_results.pop_front();
					if (rsp.accepted !== want.accepted || rsp.evicted !== want.evicted ||
					    rsp.placed_at !== want.placed_at ||
					    rsp.entry_count !== want.entry_count ||
					    rsp.entry_valid !== want.entry_valid ||
					    rsp.entry_key !== want.entry_key ||
					    rsp.entry_payload !== want.entry_payload) begin
						if (mismatches < 10) begin
							$display("[%0t] mismatch exp: acc=%b ev=%b at=%0d cnt=%0d hit=%b key=%h tag=%h",
								$time, want.accepted, want.evicted, want.placed_at,
								want.entry_count, want.entry_valid, want.entry_key,
								want.entry_payload);
							$display("             got: acc=%b ev=%b at=%0d cnt=%0d hit=%b key=%h tag=%h",
								rsp.accepted, rsp.evicted, rsp.placed_at, rsp.entry_count,
								rsp.entry_valid, rsp.entry_key, rsp.entry_payload);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req_valid && !req_stall) begin
				predicted = apply_to_mirror(req);
				due_results.push_back(predicted);
				n_items <= n_items + 1;
				if (predicted.accepted)
					n_placed <= n_placed + 1;
				if (predicted.evicted)
					n_evicted <= n_evicted + 1;
				if (req.operation == OP_INSERT && !predicted.accepted)
					n_rejected <= n_rejected + 1;
				if (predicted.entry_valid)
					n_read_hits <= n_read_hits + 1;
			end
			outstanding <= due_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the sorted insert table: request and stall stimulus, verdict.
`timescale 1ns / 1ps
module tb;
	import bsit_pkg::*;

	localparam int HOLD_CYCLES      = 150;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_PER_PHASE = 150;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int n_items;
	int n_placed;
	int n_evicted;
	int n_rejected;
	int n_read_hits;

	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct       = 0;
	logic        hold_req        = 1'b0;
	int          cycle_count     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bounded_sorted_insert_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	top_k_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.n_items     (n_items),
		.n_placed    (n_placed),
		.n_evicted   (n_evicted),
		.n_rejected  (n_rejected),
		.n_read_hits (n_read_hits)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off when asked.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  <= 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic req_t make_req(op_t op, logic [31:0] key, logic [15:0] tag,
	                                  logic [4:0] idx);
		req_t r;
		r.operation   = op;
		r.sort_key    = key;
		r.payload_tag = tag;
		r.read_index  = idx;
		return r;
	endfunction

	// Dense small keys give ties; extremes and wide randoms push the top of the table.
	function automatic logic [31:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return 32'($urandom_range(63));
		else if (r < 45)
			return 32'h0;
		else if (r < 50)
			return 32'hFFFF_FFFF;
		else
			return $urandom();
	endfunction

	// Clears are rare so the table fills and starts evicting and turning items away.
	function automatic req_t random_req();
		req_t        r;
		int unsigned pick;
		pick          = $urandom_range(99);
		r.sort_key    = pick_key();
		r.payload_tag = 16'($urandom());
		r.read_index  = 5'($urandom());
		if (pick < 62)
			r.operation = OP_INSERT;
		else if (pick < 97)
			r.operation = OP_READ;
		else if (pick < 99)
			r.operation = OP_NONE;
		else
			r.operation = OP_CLEAR;
		return r;
	endfunction

	task automatic send_item(req_t r);
		int unsigned idle;
		idle = 0;
		while ($urandom_range(99) < sender_idle_pct)
			idle++;
		if (idle > 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic run_phase(int unsigned idle_pct, int unsigned stall);
		int i;
		sender_idle_pct = idle_pct;
		stall_pct      <= stall;
		send_item(make_req(OP_CLEAR, pick_key(), 16'($urandom()), 5'($urandom())));
		for (i = 0; i < RANDOM_PER_PHASE; i++)
			send_item(random_req());
		wait_drained();
	endtask

	initial begin
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, no-op, extremes, ties, reads in and out of range, clear
		send_item(make_req(OP_READ, 32'h0, 16'h0, 5'd0));
		send_item(make_req(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 5'd31));
		send_item(make_req(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 5'd31));
		send_item(make_req(OP_INSERT, 32'h0, 16'h0000, 5'd0));
		send_item(make_req(OP_INSERT, 32'h0, 16'h0001, 5'd0));
		send_item(make_req(OP_INSERT, 32'h8000_0000, 16'hA5A5, 5'd0));
		send_item(make_req(OP_INSERT, 32'hFFFF_FFFF, 16'h5A5A, 5'd0));
		for (i = 0; i < 6; i++)
			send_item(make_req(OP_READ, 32'h0, 16'h0, 5'(i)));
		send_item(make_req(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 5'd31));
		send_item(make_req(OP_CLEAR, 32'h0, 16'h0, 5'd0));
		send_item(make_req(OP_READ, 32'h0, 16'h0, 5'd0));
		send_item(make_req(OP_INSERT, 32'h0, 16'h1234, 5'd0));
		send_item(make_req(OP_INSERT, 32'h7, 16'hBEEF, 5'd0));
		send_item(make_req(OP_READ, 32'h0, 16'h0, 5'd1));
		send_item(make_req(OP_NONE, 32'h0, 16'h0, 5'd0));
		wait_drained();

		run_phase(0, 0);
		run_phase(76, 0);
		run_phase(0, 76);
		run_phase(25, 25);

		// long result hold-off while requests keep coming, so the input backs up
		sender_idle_pct = 0;
		stall_pct      <= 0;
		hold_req       <= 1'b1;
		for (i = 0; i < 16; i++)
			send_item(random_req());
		wait_drained();

		repeat (4) @(posedge clk);
		$display("Covered %0d items: %0d placed (%0d pushed out the tail), %0d turned away,",
			n_items, n_placed, n_evicted, n_rejected);
		$display("%0d reads of filled slots, over four idle/stall mixes and a long result hold.",
			n_read_hits);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
